// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds whenever the antecedent holds, checked in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Holds in the cycle after the antecedent holds.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ucd_pkg.sv =====
`timescale 1ns / 1ps
package ucd_pkg;

  localparam int unsigned DefMaxVertices = 256;
  localparam int unsigned DefMaxEdges    = 1024;
  localparam int unsigned VertexW        = 8;
  localparam int unsigned CountW         = 9;

  localparam logic [1:0] ErrNone     = 2'd0;
  localparam logic [1:0] ErrRange    = 2'd1;
  localparam logic [1:0] ErrOverflow = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HEAD_A,
    S_LINK_A,
    S_LINK_B,
    S_SCAN,
    S_STEP,
    S_NEIGH,
    S_PUSH,
    S_POP,
    S_RESULT
  } state_e;

endpackage

// ===== design/ucd_ram.sv =====
`timescale 1ns / 1ps
module ucd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port; a read of the entry being
  // written returns the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/undirected_cycle_detect_core.sv =====
`timescale 1ns / 1ps
// Channel   | Signals                                   | Content
// ----------+-------------------------------------------+-------------------------------
// edge in   | s_axis_tvalid/tready/tdata/tuser/tlast    | end_a, end_b, has_edge, is_last
// result    | m_axis_tvalid/tready/tdata                | has_cycle, error_code
// config    | cfg_we_i, cfg_wdata_i                     | vertex_count
//
// An edge beat runs through the accept, one head read, then two slot writes, each
// a read-modify-write of the list head memory. A marker beat is taken on its accept alone.
// After the last beat the walk scans each vertex through S_SCAN and S_PUSH, visits
// each adjacency slot through S_STEP, S_NEIGH and S_PUSH and leaves each finished
// vertex through S_STEP and then S_POP or S_SCAN, paced by the head and slot memory reads.
// Reset and each result clear the head valid bits at once; the visited marks live
// in the head memory under those bits, so no clearing pass is needed.
// A waiting result stalls only the next result, not the loading of edges.
module undirected_cycle_detect_core #(
  parameter int unsigned MAX_VERTICES = ucd_pkg::DefMaxVertices,
  parameter int unsigned MAX_EDGES    = ucd_pkg::DefMaxEdges
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] end_a, [15:8] end_b
  input  logic        s_axis_tuser,   // [0] has_edge
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] has_cycle, [2:1] error_code, [7:3] zero
);

  localparam int unsigned Slots = 2 * MAX_EDGES;
  localparam int unsigned SW    = $clog2(Slots + 1);
  localparam int unsigned SAW   = $clog2(Slots);
  localparam int unsigned VW    = $clog2(MAX_VERTICES);
  localparam int unsigned NCW   = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EW    = ucd_pkg::VertexW;
  localparam int unsigned FW    = 2 * VW + 1 + SW;
  localparam logic [SW-1:0] Empty = SW'(Slots);

  typedef struct packed {
    logic [VW-1:0] vertex;
    logic [VW-1:0] parent;
    logic          has_parent;
    logic [SW-1:0] cursor;
  } frame_t;

  ucd_pkg::state_e state_q, state_d;

  logic [ucd_pkg::CountW-1:0] cfg_q;
  logic [NCW-1:0]  eff_n;
  logic [EW-1:0]   a_q, b_q;
  logic            last_q;
  logic [SW-1:0]   fill_q, fill_d;
  logic [1:0]      err_q, err_d;
  logic [NCW-1:0]  scan_q, scan_d;
  logic [NCW-1:0]  depth_q, depth_d;
  logic [VW-1:0]   nb_q, nb_d;
  frame_t          top_q, top_d;
  logic [MAX_VERTICES-1:0] hv_q, hv_d;
  logic            ovalid_q, ovalid_d, cyc_q, cyc_d, ocyc_q, ocyc_d;
  logic [1:0]      oerr_q, oerr_d;

  // Memory ports. A head word holds the visited mark above the list head.
  logic            head_we;
  logic [VW-1:0]   head_waddr, head_raddr;
  logic [SW:0]     head_wdata, head_rdata;
  logic            slot_we;
  logic [SAW-1:0]  slot_waddr, slot_raddr;
  logic [EW+SW-1:0] slot_wdata, slot_rdata;
  logic            stk_we;
  logic [VW-1:0]   stk_waddr, stk_raddr;
  logic [FW-1:0]   stk_wdata, stk_rdata;

  logic            in_fire, bad_range, no_room, scan_done, cur_empty, nb_seen;
  logic [VW-1:0]   va, vb, vscan, nb_mem;
  logic [NCW-1:0]  depth_m1, depth_m2;
  logic [SW-1:0]   head_a, head_b, head_nb;
  logic [1:0]      err_edge;

  ucd_ram #(.Width(SW + 1), .Depth(MAX_VERTICES)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(head_raddr), .rdata_o(head_rdata)
  );

  ucd_ram #(.Width(EW + SW), .Depth(Slots)) u_slot (
    .clk_i, .we_i(slot_we), .waddr_i(slot_waddr), .wdata_i(slot_wdata),
    .raddr_i(slot_raddr), .rdata_o(slot_rdata)
  );

  ucd_ram #(.Width(FW), .Depth(MAX_VERTICES)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  // Saturated vertex count and per-beat checks.
  assign eff_n = (32'(cfg_q) > MAX_VERTICES) ? NCW'(MAX_VERTICES) : NCW'(cfg_q);
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign bad_range = (32'(s_axis_tdata[7:0]) >= 32'(eff_n))
                  || (32'(s_axis_tdata[15:8]) >= 32'(eff_n));
  assign no_room   = (32'(fill_q) + 32'd2) > Slots;
  assign err_edge  = bad_range ? ucd_pkg::ErrRange :
                     no_room   ? ucd_pkg::ErrOverflow : ucd_pkg::ErrNone;

  assign va       = VW'(a_q);
  assign vb       = VW'(b_q);
  assign vscan    = scan_q[VW-1:0];
  assign nb_mem   = VW'(slot_rdata[EW+SW-1:SW]);
  assign depth_m1 = depth_q - NCW'(1);
  assign depth_m2 = depth_q - NCW'(2);
  assign scan_done = scan_q >= eff_n;
  assign cur_empty = top_q.cursor >= Empty;

  // List heads read as empty and unvisited until written in this graph; the
  // second slot of a self-loop forwards the slot just written.
  assign head_a  = hv_q[va] ? head_rdata[SW-1:0] : Empty;
  assign head_b  = (a_q == b_q) ? (fill_q - SW'(1))
                                : (hv_q[vb] ? head_rdata[SW-1:0] : Empty);
  assign head_nb = hv_q[nb_q] ? head_rdata[SW-1:0] : Empty;
  assign nb_seen = hv_q[nb_q] && head_rdata[SW];

  assign s_axis_tready = (state_q == ucd_pkg::S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {5'd0, oerr_q, ocyc_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ucd_pkg::S_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser && err_edge == ucd_pkg::ErrNone) begin
            state_d = ucd_pkg::S_HEAD_A;
          end else if (s_axis_tlast) begin
            state_d = (err_d != ucd_pkg::ErrNone) ? ucd_pkg::S_RESULT : ucd_pkg::S_SCAN;
          end
        end
      end
      ucd_pkg::S_HEAD_A: state_d = ucd_pkg::S_LINK_A;
      ucd_pkg::S_LINK_A: state_d = ucd_pkg::S_LINK_B;
      ucd_pkg::S_LINK_B: begin
        if (!last_q) begin
          state_d = ucd_pkg::S_IDLE;
        end else if (err_q != ucd_pkg::ErrNone) begin
          state_d = ucd_pkg::S_RESULT;
        end else begin
          state_d = ucd_pkg::S_SCAN;
        end
      end
      ucd_pkg::S_SCAN: begin
        if (scan_done) begin
          state_d = ucd_pkg::S_RESULT;
        end else begin
          state_d = ucd_pkg::S_PUSH;
        end
      end
      ucd_pkg::S_STEP: begin
        if (!cur_empty) begin
          state_d = ucd_pkg::S_NEIGH;
        end else if (depth_q == NCW'(1)) begin
          state_d = ucd_pkg::S_SCAN;
        end else begin
          state_d = ucd_pkg::S_POP;
        end
      end
      ucd_pkg::S_NEIGH: state_d = ucd_pkg::S_PUSH;
      ucd_pkg::S_PUSH: begin
        if (!nb_seen) begin
          state_d = ucd_pkg::S_STEP;
        end else if (depth_q == '0) begin
          state_d = ucd_pkg::S_SCAN;
        end else if (!top_q.has_parent || nb_q != top_q.parent) begin
          state_d = ucd_pkg::S_RESULT;
        end else begin
          state_d = ucd_pkg::S_STEP;
        end
      end
      ucd_pkg::S_POP:  state_d = ucd_pkg::S_STEP;
      ucd_pkg::S_RESULT: begin
        if (!ovalid_q || m_axis_tready) begin
          state_d = ucd_pkg::S_IDLE;
        end
      end
      default: state_d = ucd_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    fill_d = fill_q;
    err_d = err_q;
    scan_d = scan_q;
    depth_d = depth_q;
    nb_d = nb_q;
    top_d = top_q;
    hv_d = hv_q;
    cyc_d = cyc_q;
    ocyc_d = ocyc_q;
    oerr_d = oerr_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    head_we = 1'b0;
    head_waddr = va;
    head_wdata = {1'b0, fill_q};
    head_raddr = va;
    slot_we = 1'b0;
    slot_waddr = fill_q[SAW-1:0];
    slot_wdata = {b_q, head_a};
    slot_raddr = top_q.cursor[SAW-1:0];
    stk_we = 1'b0;
    stk_waddr = depth_m1[VW-1:0];
    stk_wdata = top_q;
    stk_raddr = depth_m2[VW-1:0];
    case (state_q)
      ucd_pkg::S_IDLE: begin
        if (in_fire && s_axis_tuser && err_q == ucd_pkg::ErrNone) begin
          err_d = err_edge;
        end
        cyc_d = 1'b0;
        scan_d = '0;
        depth_d = '0;
      end
      ucd_pkg::S_LINK_A: begin
        // Append b to the list of a and read the head of b.
        slot_we = 1'b1;
        head_we = 1'b1;
        hv_d[va] = 1'b1;
        fill_d = fill_q + SW'(1);
        head_raddr = vb;
      end
      ucd_pkg::S_LINK_B: begin
        // Append a to the list of b.
        slot_we = 1'b1;
        slot_wdata = {a_q, head_b};
        head_we = 1'b1;
        head_waddr = vb;
        hv_d[vb] = 1'b1;
        fill_d = fill_q + SW'(1);
      end
      ucd_pkg::S_SCAN: begin
        // Read the head word of the next start vertex.
        head_raddr = vscan;
        nb_d = vscan;
        if (!scan_done) begin
          scan_d = scan_q + NCW'(1);
        end
      end
      ucd_pkg::S_STEP: begin
        if (cur_empty) begin
          depth_d = depth_m1;
        end
      end
      ucd_pkg::S_NEIGH: begin
        // Advance the cursor and read the head word of the neighbor.
        top_d.cursor = slot_rdata[SW-1:0];
        nb_d = nb_mem;
        head_raddr = nb_mem;
      end
      ucd_pkg::S_PUSH: begin
        // Open a frame for an unvisited vertex and mark it visited; a visited
        // neighbor other than the parent closes a cycle.
        if (!nb_seen) begin
          stk_we = (depth_q != '0);
          top_d.vertex = nb_q;
          top_d.parent = top_q.vertex;
          top_d.has_parent = (depth_q != '0);
          top_d.cursor = head_nb;
          depth_d = depth_q + NCW'(1);
          head_we = 1'b1;
          head_waddr = nb_q;
          head_wdata = {1'b1, head_nb};
          hv_d[nb_q] = 1'b1;
        end else if (depth_q != '0 && (!top_q.has_parent || nb_q != top_q.parent)) begin
          cyc_d = 1'b1;
        end
      end
      ucd_pkg::S_POP: begin
        top_d = frame_t'(stk_rdata);
      end
      ucd_pkg::S_RESULT: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          oerr_d = err_q;
          ocyc_d = cyc_q;
          hv_d = '0;
          fill_d = '0;
          err_d = ucd_pkg::ErrNone;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ucd_pkg::S_IDLE;
      cfg_q    <= ucd_pkg::CountW'(256);
      fill_q   <= '0;
      err_q    <= ucd_pkg::ErrNone;
      hv_q     <= '0;
      ovalid_q <= 1'b0;
      depth_q  <= '0;
      scan_q   <= '0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      fill_q   <= fill_d;
      err_q    <= err_d;
      hv_q     <= hv_d;
      ovalid_q <= ovalid_d;
      depth_q  <= depth_d;
      scan_q   <= scan_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_q    <= s_axis_tdata[7:0];
      b_q    <= s_axis_tdata[15:8];
      last_q <= s_axis_tlast;
    end
    nb_q   <= nb_d;
    top_q  <= top_d;
    cyc_q  <= cyc_d;
    ocyc_q <= ocyc_d;
    oerr_q <= oerr_d;
  end

endmodule

// ===== design/ucd_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ucd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  // A held result beat stays until taken.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")

  // A held result beat keeps its data.
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed")

  // Only defined error codes appear.
  `ASSERT_SAME(a_err_code, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[2:1] != 2'd3, "bad error code")

  // An erroneous graph never reports a cycle.
  `ASSERT_SAME(a_err_nocyc, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[2:1] != 2'd0, !m_axis_tdata[0], "cycle with error")

  // The pad bits of a result beat stay zero.
  `ASSERT_SAME(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[7:3] == 5'd0, "pad bits set")

endmodule

bind undirected_cycle_detect_core ucd_checker u_ucd_checker (.*);
